// File: design/swp_pkg.sv
// Shared types and constants for the stop-and-wait packetizer.
package swp_pkg;

	localparam int PayloadDefault    = 50;
	localparam int StoreDepthDefault = 4096;

	// Fixed field widths
	localparam int AddrW  = 12;
	localparam int ByteW  = 8;
	localparam int SeqW   = 6;
	localparam int TimerW = 16;
	localparam int CfgW   = 16;

	// Bit 6 of header byte 0 marks the last packet
	localparam logic [ByteW-1:0] LastFlag = 8'h40;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_ACK   = 2'd2,
		FUNC_TICK  = 2'd3
	} func_t;

	typedef enum logic {
		CFG_MESSAGE_LENGTH    = 1'b0,
		CFG_ACK_TIMEOUT_TICKS = 1'b1
	} cfg_index_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_SEND
	} seq_state_t;

	typedef struct packed {
		func_t            func;
		logic [AddrW-1:0] load_address;
		logic [ByteW-1:0] load_data;
	} in_item_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             out_last;
		logic             retransmit;
		logic             final_packet;
	} out_item_t;

	// Packet request from the control unit to the sequencer
	typedef struct packed {
		logic             start;
		logic [AddrW-1:0] offset;
		logic [ByteW-1:0] count;
		logic [SeqW-1:0]  seq;
		logic             fin;
		logic             resend;
	} pkt_cmd_t;

endpackage

// File: design/swp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module swp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/swp_ctrl.sv
// Request decode, configuration registers and sender state (offset, sequence, timer).
module swp_ctrl import swp_pkg::*; #(
	parameter int PAYLOAD     = PayloadDefault,
	parameter int STORE_DEPTH = StoreDepthDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  in_item_t                       in_item,
	input  logic                           busy,
	input  logic                           cfg_write,
	input  cfg_index_t                     cfg_index,
	input  logic [CfgW-1:0]                cfg_data,
	output logic                           store_we,
	output logic [$clog2(STORE_DEPTH)-1:0] store_waddr,
	output logic [ByteW-1:0]               store_wdata,
	output pkt_cmd_t                       cmd
);

	localparam int LenW = AddrW + 1;

	logic [AddrW-1:0]  off_q, off_d;
	logic [SeqW-1:0]   seq_q, seq_d;
	logic              await_q, await_d;
	logic [TimerW-1:0] wc_q, wc_d, wc_inc;
	logic [AddrW-1:0]  len_q;
	logic [TimerW-1:0] tmo_q;

	logic              accept;
	logic [LenW-1:0]   eff_len;
	logic [LenW-1:0]   cur_end;
	logic              cur_fin;
	logic              emit;
	logic              resend;
	logic [AddrW-1:0]  emit_off;
	logic [LenW-1:0]   emit_end;
	logic [LenW-1:0]   remain;

	assign accept  = in_valid && !busy;
	assign eff_len = ({1'b0, len_q} > LenW'(STORE_DEPTH)) ? LenW'(STORE_DEPTH) : {1'b0, len_q};
	assign cur_end = {1'b0, off_q} + LenW'(PAYLOAD);
	assign cur_fin = cur_end >= eff_len;
	assign wc_inc  = wc_q + TimerW'(1);

	always_comb begin
		off_d    = off_q;
		seq_d    = seq_q;
		await_d  = await_q;
		wc_d     = wc_q;
		emit     = 1'b0;
		resend   = 1'b0;
		emit_off = off_q;
		store_we = 1'b0;
		if (accept) begin
			unique case (in_item.func)
				FUNC_LOAD: begin
					store_we = {1'b0, in_item.load_address} < LenW'(STORE_DEPTH);
				end
				FUNC_START: begin
					emit = 1'b1;
				end
				FUNC_ACK: begin
					if (await_q) begin
						if (cur_fin) begin
							// wrap to the start and go idle
							off_d   = '0;
							seq_d   = '0;
							await_d = 1'b0;
							wc_d    = '0;
						end else begin
							off_d    = cur_end[AddrW-1:0];
							emit_off = cur_end[AddrW-1:0];
							seq_d    = seq_q + SeqW'(1);
							emit     = 1'b1;
						end
					end
				end
				FUNC_TICK: begin
					if (await_q) begin
						wc_d = wc_inc;
						if (wc_inc >= tmo_q || wc_inc == '0) begin
							emit   = 1'b1;
							resend = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			if (emit) begin
				await_d = 1'b1;
				wc_d    = '0;
			end
		end
	end

	// Packet geometry at the offset being sent
	assign emit_end = {1'b0, emit_off} + LenW'(PAYLOAD);
	assign remain   = eff_len - {1'b0, emit_off};

	always_comb begin
		cmd        = '0;
		cmd.start  = emit;
		cmd.offset = emit_off;
		cmd.seq    = seq_d;
		cmd.fin    = emit_end >= eff_len;
		cmd.resend = resend;
		if ({1'b0, emit_off} >= eff_len) begin
			cmd.count = '0;
		end else if (remain > LenW'(PAYLOAD)) begin
			cmd.count = ByteW'(PAYLOAD);
		end else begin
			cmd.count = remain[ByteW-1:0];
		end
	end

	assign store_waddr = in_item.load_address[$clog2(STORE_DEPTH)-1:0];
	assign store_wdata = in_item.load_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			seq_q   <= '0;
			await_q <= 1'b0;
			wc_q    <= '0;
			len_q   <= AddrW'(50);
			tmo_q   <= TimerW'(5);
		end else begin
			off_q   <= off_d;
			seq_q   <= seq_d;
			await_q <= await_d;
			wc_q    <= wc_d;
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_MESSAGE_LENGTH:    len_q <= cfg_data[AddrW-1:0];
					CFG_ACK_TIMEOUT_TICKS: tmo_q <= cfg_data[TimerW-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: design/swp_seq.sv
// Packet sequencer: walks the packet bytes, reads the store and drives the output register.
module swp_seq import swp_pkg::*; #(
	parameter int PAYLOAD     = PayloadDefault,
	parameter int STORE_DEPTH = StoreDepthDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pkt_cmd_t                       cmd,
	output logic                           busy,
	output logic                           rd_en,
	output logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
	input  logic [ByteW-1:0]               rd_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output out_item_t                      out_item
);

	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int KW   = $clog2(PAYLOAD + 2);
	localparam int LenW = AddrW + 1;

	seq_state_t       state_q, state_d;
	logic [KW-1:0]    idx_q;
	logic [AddrW-1:0] off_q;
	logic [ByteW-1:0] count_q;
	logic [SeqW-1:0]  seq_q;
	logic             fin_q;
	logic             resend_q;

	logic             s1_valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             use_ram_s1;
	logic             last_s1;
	logic             resend_s1;
	logic             fin_s1;

	logic             out_valid_q;
	out_item_t        out_q;

	logic             out_free;
	logic             s1_adv;
	logic             issue;
	logic             is_last;
	logic [KW-1:0]    data_idx;
	logic             is_data;
	logic [ByteW-1:0] issue_byte;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = s1_valid_s1 && out_free;
	assign is_last  = idx_q == KW'(PAYLOAD + 1);
	assign data_idx = idx_q - KW'(2);
	assign is_data  = (idx_q >= KW'(2)) && (ByteW'(data_idx) < count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: if (cmd.start) state_d = SEQ_SEND;
			SEQ_SEND: if (issue && is_last) state_d = SEQ_IDLE;
			default:  state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		issue      = 1'b0;
		issue_byte = '0;
		unique case (state_q)
			SEQ_IDLE: begin
				issue = 1'b0;
			end
			SEQ_SEND: begin
				issue = !s1_valid_s1 || s1_adv;
				if (idx_q == '0) begin
					issue_byte = {1'b0, fin_q, seq_q} | (fin_q ? LastFlag : '0);
				end else if (idx_q == KW'(1)) begin
					issue_byte = count_q;
				end
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	assign busy    = state_q == SEQ_SEND;
	assign rd_en   = issue && is_data;
	assign rd_addr = AW'(LenW'(off_q) + LenW'(data_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			idx_q       <= '0;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == SEQ_IDLE && cmd.start) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + KW'(1);
			end
			if (issue) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_IDLE && cmd.start) begin
			off_q    <= cmd.offset;
			count_q  <= cmd.count;
			seq_q    <= cmd.seq;
			fin_q    <= cmd.fin;
			resend_q <= cmd.resend;
		end
		if (issue) begin
			byte_s1    <= issue_byte;
			use_ram_s1 <= is_data;
			last_s1    <= is_last;
			resend_s1  <= resend_q;
			fin_s1     <= fin_q;
		end
		if (s1_adv) begin
			out_q.out_byte     <= use_ram_s1 ? rd_data : byte_s1;
			out_q.out_last     <= last_s1;
			out_q.retransmit   <= resend_s1;
			out_q.final_packet <= fin_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: design/stop_and_wait_packetizer_core.sv
// Stop-and-wait packet sender: message store, control unit and packet sequencer.
// A start, non-final ack or timeout request produces PAYLOAD+2 bytes; the first passes the
// command registers, stage 1 and the output register, then one byte per cycle while the output is not stalled.
// No new packet request is taken while the sequencer is busy sending the current packet.
// Load, idle ack and idle tick requests launch no packet. Reset clears offset, sequence,
// timer and pipeline; the message store is not cleared and needs loading before use.
module stop_and_wait_packetizer_core import swp_pkg::*; #(
	parameter int PAYLOAD     = PayloadDefault,
	parameter int STORE_DEPTH = StoreDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  in_item_t        in_item,
	output logic            out_valid,
	input  logic            out_stall,
	output out_item_t       out_item,
	input  logic            cfg_write,
	input  cfg_index_t      cfg_index,
	input  logic [CfgW-1:0] cfg_data
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic             busy;
	pkt_cmd_t         cmd;
	logic             store_we;
	logic [AW-1:0]    store_waddr;
	logic [ByteW-1:0] store_wdata;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [ByteW-1:0] rd_data;

	swp_ctrl #(
		.PAYLOAD    (PAYLOAD),
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_item    (in_item),
		.busy       (busy),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.store_we   (store_we),
		.store_waddr(store_waddr),
		.store_wdata(store_wdata),
		.cmd        (cmd)
	);

	swp_ram #(
		.WIDTH(ByteW),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(store_waddr),
		.wdata(store_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	swp_seq #(
		.PAYLOAD    (PAYLOAD),
		.STORE_DEPTH(STORE_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	assign in_stall = busy;

	// A start request always launches a packet
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.func == FUNC_START |=> in_stall)
		else $error("start request did not launch a packet");

	// A load request never launches a packet
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.func == FUNC_LOAD |=> !in_stall)
		else $error("load request made the sender busy");

	// Output cannot appear without a packet in flight
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !out_valid && !$past(in_stall) |=> !out_valid)
		else $error("output byte without a packet in flight");

endmodule

// File: verif/stop_and_wait_packetizer_core_tb.sv
// Self-checking testbench for the stop-and-wait packetizer core.
module stop_and_wait_packetizer_core_tb;
	import swp_pkg::*;

	localparam int PAYLOAD       = PayloadDefault;
	localparam int STORE_DEPTH   = StoreDepthDefault;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES        = 7;

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_stall;
	in_item_t        in_item   = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	out_item_t       out_item;
	logic            cfg_write = 1'b0;
	cfg_index_t      cfg_index = CFG_MESSAGE_LENGTH;
	logic [CfgW-1:0] cfg_data  = '0;

	stop_and_wait_packetizer_core #(
		.PAYLOAD     (PAYLOAD),
		.STORE_DEPTH (STORE_DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Packetizer state as predicted from accepted requests
	logic [ByteW-1:0]  msg_store [STORE_DEPTH];
	logic [AddrW-1:0]  send_offset   = '0;
	logic [SeqW-1:0]   seq_count     = '0;
	logic              awaiting      = 1'b0;
	logic [TimerW-1:0] tick_count    = '0;
	logic [AddrW-1:0]  message_len   = 12'd50;
	logic [TimerW-1:0] timeout_ticks = 16'd5;

	out_item_t expected_bytes [$];
	in_item_t  pending_requests [$];
	bit        loaded [STORE_DEPTH];
	int        error_count   = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	logic      req_taken     = 1'b0;

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic void queue_packet(logic resend);
		int        count;
		logic      fin;
		out_item_t r;
		count = 0;
		if (send_offset < message_len) begin
			count = int'(message_len) - int'(send_offset);
			if (count > PAYLOAD)
				count = PAYLOAD;
		end
		fin = (int'(send_offset) + PAYLOAD >= int'(message_len));
		for (int k = 0; k < PAYLOAD + 2; k++) begin
			if (k == 0)
				r.out_byte = {2'b00, seq_count} | (fin ? LastFlag : '0);
			else if (k == 1)
				r.out_byte = ByteW'(count);
			else if (k - 2 < count)
				r.out_byte = msg_store[(int'(send_offset) + k - 2) % STORE_DEPTH];
			else
				r.out_byte = '0;
			r.out_last     = (k == PAYLOAD + 1);
			r.retransmit   = resend;
			r.final_packet = fin;
			expected_bytes.push_back(r);
		end
		awaiting   = 1'b1;
		tick_count = '0;
	endfunction

	function automatic void predict_request(in_item_t r);
		case (r.func)
			FUNC_LOAD: begin
				msg_store[r.load_address] = r.load_data;
			end
			FUNC_START: begin
				queue_packet(1'b0);
			end
			FUNC_ACK: begin
				if (awaiting) begin
					// wrap to idle once the last packet is acknowledged
					if (int'(send_offset) + PAYLOAD >= int'(message_len)) begin
						send_offset = '0;
						seq_count   = '0;
						awaiting    = 1'b0;
						tick_count  = '0;
					end else begin
						send_offset = send_offset + AddrW'(PAYLOAD);
						seq_count   = seq_count + 1'b1;
						queue_packet(1'b0);
					end
				end
			end
			default: begin
				if (awaiting) begin
					tick_count = tick_count + 1'b1;
					if (tick_count >= timeout_ticks || tick_count == '0)
						queue_packet(1'b1);
				end
			end
		endcase
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		if (expected_bytes.size() == 0) begin
			flag_error($sformatf("unexpected result: byte %02h last %0b resend %0b final %0b",
				got.out_byte, got.out_last, got.retransmit, got.final_packet));
			return;
		end
		want = expected_bytes.pop_front();
		if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
			got.retransmit !== want.retransmit || got.final_packet !== want.final_packet)
			flag_error($sformatf({"mismatch: expected byte %02h last %0b resend %0b final %0b,",
				" got byte %02h last %0b resend %0b final %0b"},
				want.out_byte, want.out_last, want.retransmit, want.final_packet,
				got.out_byte, got.out_last, got.retransmit, got.final_packet));
	endfunction

	always @(posedge clk) begin
		req_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			predict_request(in_item);
		if (arst_n && out_valid && !out_stall)
			check_result(out_item);
	end

	// Hold a stalled request, otherwise present the next one or idle
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_item  <= pending_requests.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	function automatic void add_request(func_t f, logic [AddrW-1:0] addr,
		logic [ByteW-1:0] data);
		in_item_t r;
		r.func         = f;
		r.load_address = addr;
		r.load_data    = data;
		pending_requests.push_back(r);
		if (f == FUNC_LOAD)
			loaded[addr] = 1'b1;
	endfunction

	function automatic void add_command(func_t f);
		add_request(f, AddrW'($urandom_range(0, 4095)), ByteW'($urandom_range(0, 255)));
	endfunction

	// Load every message byte that a packet could read and that holds nothing yet
	function automatic void fill_message();
		for (int a = 0; a < int'(message_len); a++)
			if (!loaded[a])
				add_request(FUNC_LOAD, AddrW'(a), ByteW'($urandom_range(0, 255)));
	endfunction

	function automatic int tick_cap();
		if (timeout_ticks == '0)
			return 1;
		if (timeout_ticks >= 16'd8)
			return 8;
		return int'(timeout_ticks) + 1;
	endfunction

	// Mostly complete send sequences, with stray starts, loads, acks, ticks and abandoned runs
	function automatic void send_traffic(int budget);
		int issued;
		int packets;
		int ticks;
		issued = 0;
		while (issued < budget) begin
			add_command(FUNC_START);
			issued++;
			packets = (int'(message_len) + PAYLOAD - 1) / PAYLOAD;
			if (packets == 0)
				packets = 1;
			for (int pk = 0; pk < packets && issued < budget; pk++) begin
				ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, tick_cap()) : 0;
				repeat (ticks) add_command(FUNC_TICK);
				issued += ticks;
				if ($urandom_range(0, 19) == 0) begin
					add_command(FUNC_START);
					issued++;
				end
				if ($urandom_range(0, 19) == 0)
					add_command(FUNC_LOAD);
				if ($urandom_range(0, 4 * packets) == 0)
					break;
				add_command(FUNC_ACK);
				issued++;
			end
			if ($urandom_range(0, 4) == 0)
				add_command($urandom_range(0, 1) ? FUNC_ACK : FUNC_TICK);
		end
	endfunction

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_index_t idx, logic [CfgW-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == CFG_MESSAGE_LENGTH)
			message_len = value[AddrW-1:0];
		else
			timeout_ticks = value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin : stimulus
		int phase_len [PHASES];
		int phase_timeout [PHASES];
		int phase_budget [PHASES];

		phase_len = '{250, 1, 0, 237, 0, 101, 0};
		phase_timeout = '{65535, 1, 0, 3, 0, 2, 0};
		phase_budget = '{30, 10, 15, 30, 15, 10, 15};
		phase_len[2] = $urandom_range(51, 250);
		phase_timeout[2] = $urandom_range(2, 8);
		phase_len[4] = $urandom_range(1, 200);
		phase_timeout[4] = $urandom_range(1, 6);
		phase_len[6] = $urandom_range(1, 250);
		phase_timeout[6] = $urandom_range(0, 10);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 27;
		recv_idle_pct = 61;

		// Reset settings: one full packet that is also the last one
		add_command(FUNC_ACK);
		add_command(FUNC_TICK);
		add_request(FUNC_LOAD, 12'hFFF, 8'hFF);
		add_request(FUNC_LOAD, 12'h555, 8'hAA);
		fill_message();
		add_request(FUNC_LOAD, 12'd0, 8'h00);
		add_request(FUNC_LOAD, 12'd49, 8'hFF);
		add_command(FUNC_START);
		add_command(FUNC_START);
		repeat (5) add_command(FUNC_TICK);
		add_command(FUNC_ACK);
		add_command(FUNC_TICK);
		wait_idle();

		// Three packets, short last one; zero timeout resends on every tick
		write_register(CFG_MESSAGE_LENGTH, 16'd120);
		write_register(CFG_ACK_TIMEOUT_TICKS, 16'd0);
		fill_message();
		add_command(FUNC_START);
		add_command(FUNC_TICK);
		add_command(FUNC_TICK);
		add_command(FUNC_ACK);
		add_command(FUNC_TICK);
		add_command(FUNC_ACK);
		add_command(FUNC_ACK);
		wait_idle();

		// Empty message
		write_register(CFG_MESSAGE_LENGTH, 16'd0);
		write_register(CFG_ACK_TIMEOUT_TICKS, 16'd1);
		add_command(FUNC_START);
		add_command(FUNC_ACK);
		add_command(FUNC_ACK);
		wait_idle();

		// Shorten the message while a packet past the new end is outstanding
		write_register(CFG_MESSAGE_LENGTH, 16'd200);
		write_register(CFG_ACK_TIMEOUT_TICKS, 16'd2);
		fill_message();
		add_command(FUNC_START);
		repeat (3) add_command(FUNC_ACK);
		wait_idle();
		write_register(CFG_MESSAGE_LENGTH, 16'd60);
		add_command(FUNC_TICK);
		add_command(FUNC_TICK);
		add_command(FUNC_ACK);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 3) begin
				send_idle_pct = 27;
				recv_idle_pct = 61;
			end else if (p < 5) begin
				send_idle_pct = 61;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_register(CFG_MESSAGE_LENGTH, CfgW'(phase_len[p]));
			write_register(CFG_ACK_TIMEOUT_TICKS, CfgW'(phase_timeout[p]));
			fill_message();
			send_traffic(phase_budget[p]);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
